// ===== rtl/core/cac_pkg.sv =====
// shared types and constants of the card access controller
`timescale 1ns / 1ps
`default_nettype none
package cac_pkg;
	localparam int MaxCards = 16;
	localparam int IdxW = $clog2(MaxCards);
	localparam int CntW = $clog2(MaxCards + 1);

	localparam logic [31:0] AdminUidRst = 32'hE37C7F0D;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0, OP_CARD = 3'd1, OP_ABSENT = 3'd2, OP_LEARN = 3'd3,
		OP_CANCEL = 3'd4, OP_RSTALM = 3'd5, OP_LOCK = 3'd6, OP_PIN = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		CFG_ADMIN = 3'd0, CFG_ALARM = 3'd1, CFG_LEARN = 3'd2, CFG_HOLD = 3'd3,
		CFG_WARN = 3'd4, CFG_THRESH = 3'd5
	} cfg_idx_t;

	localparam logic [2:0] LS_IDLE = 3'd0;
	localparam logic [2:0] LS_NEW = 3'd1;
	localparam logic [2:0] LS_ADMIN = 3'd2;
	localparam logic [2:0] LS_OK = 3'd3;
	localparam logic [2:0] LS_ABORT = 3'd4;
	localparam logic [2:0] LS_KNOWN = 3'd5;

	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_ALLOW = 2'd1;
	localparam logic [1:0] ST_DENY = 2'd2;
	localparam logic [1:0] ST_LEARN = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_EXEC = 4'b0100, S_OUT = 4'b1000
	} fsm_t;
endpackage
`default_nettype wire

// ===== rtl/core/card_access_controller_core.sv =====
// card access controller top level
`timescale 1ns / 1ps
`default_nettype none
// One item at a time: busy rises on the cycle after start and falls when
// done pulses with the result. A card read scans the whitelist from a
// synchronous memory one entry per cycle, then passes through the execute
// and out steps; every other item skips the scan and goes to execute.
// The result can't be held off by the receiver; it is valid only while done.
// Only entry 0 (admin) and written entries are ever read, so the memory has
// no reset pass.
module card_access_controller_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] card_uid,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_data,
	output logic [1:0]       access_state,
	output logic [2:0]       learn_phase,
	output logic             is_unlocked,
	output logic             alarm_active,
	output logic             lockout_active,
	output logic             wrong_card_warning,
	output logic [3:0]       failure_streak,
	output logic [31:0]      success_total,
	output logic [31:0]      failure_total,
	output logic             led_red,
	output logic             led_green,
	output logic             led_blue
);
	import cac_pkg::*;

	// config registers
	logic [31:0] admin_q;
	logic [15:0] alarm_to_q, learn_to_q, hold_q, warn_ms_q;
	logic [3:0]  thresh_q;

	// whitelist memory
	logic [31:0] wl_mem [MaxCards];
	logic [31:0] rd_data_q;
	logic [IdxW-1:0] rd_addr;
	logic wl_we;
	logic [IdxW-1:0] wl_waddr;
	logic [31:0] wl_wdata;

	// control state
	fsm_t state_q;
	op_t  op_q;
	logic [31:0] uid_q;
	logic [CntW-1:0] scan_q, count_q;
	logic rd_pend_q, found_q;
	logic [IdxW-1:0] found_idx_q;

	logic [31:0] pending_q, unl_uid_q;
	logic bound_q, unl_q, alarm_q, lock_q, await_q;
	logic [3:0] streak_q;
	logic [31:0] ok_q, bad_q;
	logic [2:0] lstep_q;
	logic [1:0] status_q;
	logic [31:0] now_q, alarm_since_q, learn_since_q, fb_since_q, warn_since_q, anim_since_q;
	logic warn_on_q, anim_on_q, anim_unl_q;

	// 250 ms blink phase, tracked alongside the millisecond counter
	logic [7:0] blk_cnt_q;
	logic blink_q;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admin_q <= AdminUidRst;
			alarm_to_q <= 16'd5000;
			learn_to_q <= 16'd10000;
			hold_q <= 16'd2500;
			warn_ms_q <= 16'd2000;
			thresh_q <= 4'd5;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ADMIN:  admin_q <= cfg_data;
				CFG_ALARM:  alarm_to_q <= cfg_data[15:0];
				CFG_LEARN:  learn_to_q <= cfg_data[15:0];
				CFG_HOLD:   hold_q <= cfg_data[15:0];
				CFG_WARN:   warn_ms_q <= cfg_data[15:0];
				CFG_THRESH: thresh_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// memory: entry 0 lives in admin_q, others in the array
	assign rd_addr = scan_q[IdxW-1:0];
	always_ff @(posedge clk) begin
		if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
		rd_data_q <= wl_mem[rd_addr];
	end

	// ---- next-state computation for the execute step ----
	logic [31:0] now_n;
	logic chk_ok;
	logic n_alarm, n_unl, n_bound, n_lock, n_await, n_warn_on, n_anim_on, n_anim_unl;
	logic [2:0] n_lstep;
	logic [1:0] n_status;
	logic [3:0] n_streak;
	logic [31:0] n_ok, n_bad, n_pending, n_unl_uid;
	logic [31:0] n_alarm_since, n_learn_since, n_fb_since, n_warn_since, n_anim_since;
	logic [CntW-1:0] n_count;
	logic known, is_admin;
	logic [3:0] inc_streak;

	assign known = found_q;
	assign is_admin = found_q && (found_idx_q == '0);

	always_comb begin
		now_n = (op_q == OP_TICK) ? now_q + 32'd1 : now_q;
		n_alarm = alarm_q; n_unl = unl_q; n_bound = bound_q; n_lock = lock_q;
		n_await = await_q; n_warn_on = warn_on_q; n_anim_on = anim_on_q;
		n_anim_unl = anim_unl_q; n_lstep = lstep_q; n_status = status_q;
		n_streak = streak_q; n_ok = ok_q; n_bad = bad_q; n_pending = pending_q;
		n_unl_uid = unl_uid_q; n_alarm_since = alarm_since_q;
		n_learn_since = learn_since_q; n_fb_since = fb_since_q;
		n_warn_since = warn_since_q; n_anim_since = anim_since_q; n_count = count_q;
		chk_ok = 1'b1;
		wl_we = 1'b0; wl_waddr = count_q[IdxW-1:0]; wl_wdata = pending_q;
		inc_streak = (streak_q < 4'd15) ? streak_q + 4'd1 : streak_q;

		// timeout checks
		if (op_q == OP_TICK || op_q == OP_CARD || op_q == OP_ABSENT) begin
			if (alarm_q && (now_n - alarm_since_q) >= {16'd0, alarm_to_q}) begin
				n_alarm = 1'b0;
				if (!lock_q) n_status = ST_READY;
			end
			if (lstep_q >= LS_OK) begin
				if ((now_n - fb_since_q) >= {16'd0, hold_q}) begin
					n_lstep = LS_IDLE; n_status = ST_READY; n_await = 1'b1;
				end
				chk_ok = 1'b0;
			end else if (lstep_q != LS_IDLE &&
			    (now_n - learn_since_q) >= {16'd0, learn_to_q}) begin
				n_lstep = LS_ABORT; n_fb_since = now_n; chk_ok = 1'b0;
			end
		end

		case (op_q)
			OP_CARD: begin
				if (chk_ok && !await_q) begin
					n_await = 1'b1;
					if (lstep_q == LS_NEW) begin
						if (known) begin
							n_lstep = LS_KNOWN; n_fb_since = now_n;
						end else begin
							n_pending = uid_q; n_lstep = LS_ADMIN; n_learn_since = now_n;
						end
					end else if (lstep_q == LS_ADMIN) begin
						if (known && count_q < CntW'(MaxCards)) begin
							// store only on the execute step
							wl_we = (state_q == S_EXEC);
							n_count = count_q + 1'b1;
							n_lstep = LS_OK;
						end else n_lstep = LS_ABORT;
						n_fb_since = now_n;
					end else if (lock_q) begin
						if (is_admin) begin
							n_lock = 1'b0;
							n_alarm = 1'b0; n_unl = 1'b1; n_bound = 1'b1; n_unl_uid = uid_q;
							n_ok = ok_q + 32'd1; n_streak = 4'd0; n_status = ST_ALLOW;
							n_anim_on = 1'b1; n_anim_since = now_n; n_anim_unl = 1'b1;
						end else begin
							n_bad = bad_q + 32'd1;
							n_alarm = 1'b1; n_alarm_since = now_n; n_anim_on = 1'b0;
							n_status = ST_DENY;
						end
					end else if (!unl_q) begin
						if (known) begin
							n_alarm = 1'b0; n_unl = 1'b1; n_bound = 1'b1; n_unl_uid = uid_q;
							n_ok = ok_q + 32'd1; n_streak = 4'd0; n_status = ST_ALLOW;
							n_anim_on = 1'b1; n_anim_since = now_n; n_anim_unl = 1'b1;
						end else begin
							n_streak = inc_streak;
							n_bad = bad_q + 32'd1;
							if (inc_streak >= thresh_q) n_lock = 1'b1;
							n_alarm = 1'b1; n_alarm_since = now_n; n_anim_on = 1'b0;
							n_status = ST_DENY;
						end
					end else if (known && !(bound_q && uid_q != unl_uid_q)) begin
						n_unl = 1'b0; n_bound = 1'b0; n_status = ST_READY;
						n_anim_on = 1'b1; n_anim_since = now_n; n_anim_unl = 1'b0;
					end else begin
						n_warn_on = 1'b1; n_warn_since = now_n; n_anim_on = 1'b0;
						if (!known) n_bad = bad_q + 32'd1;
					end
				end
			end
			OP_ABSENT: begin
				if (chk_ok && n_await) begin
					n_await = 1'b0;
					if (n_lstep == LS_IDLE && n_status != ST_DENY && !lock_q)
						n_status = ST_READY;
				end
			end
			OP_LEARN: begin
				if (lstep_q == LS_IDLE && !lock_q) begin
					n_lstep = LS_NEW; n_learn_since = now_q; n_status = ST_LEARN;
					n_unl = 1'b0; n_bound = 1'b0; n_anim_on = 1'b0; n_await = 1'b0;
				end
			end
			OP_CANCEL: begin
				n_lstep = LS_IDLE; n_status = ST_READY; n_anim_on = 1'b0; n_await = 1'b0;
			end
			OP_RSTALM: begin
				if (!lock_q) begin
					n_alarm = 1'b0; n_anim_on = 1'b0; n_status = ST_READY;
				end
			end
			OP_LOCK: begin
				n_unl = 1'b0; n_bound = 1'b0; n_alarm = 1'b0; n_warn_on = 1'b0;
				n_status = ST_READY;
				n_anim_on = 1'b1; n_anim_since = now_q; n_anim_unl = 1'b0;
			end
			OP_PIN: begin
				if (!lock_q) begin
					n_alarm = 1'b0; n_unl = 1'b1; n_bound = 1'b0; n_warn_on = 1'b0;
					n_streak = 4'd0; n_ok = ok_q + 32'd1; n_status = ST_ALLOW;
					n_anim_on = 1'b1; n_anim_since = now_q; n_anim_unl = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// ---- led evaluation on the updated state (registered in the out step) ----
	logic [31:0] wd, ad;
	logic [32:0] wq_prod;
	logic [20:0] aq_prod;
	logic warn_live, blink, anim_live, anim_ph, warn_ph;
	logic o_r, o_g, o_b, o_warn_keep, o_anim_keep;

	assign wd = now_q - warn_since_q;
	assign ad = now_q - anim_since_q;
	assign blink = blink_q;
	// phase bits by reciprocal multiply; only used inside the live windows,
	// where wd fits 16 bits and ad stays under 1000
	assign wq_prod = {17'd0, wd[15:0]} * 33'd111849;
	assign warn_ph = !wq_prod[24];
	assign aq_prod = {11'd0, ad[9:0]} * 21'd1049;
	assign anim_ph = !aq_prod[17];

	always_comb begin
		warn_live = warn_on_q && (wd < {16'd0, warn_ms_q});
		o_warn_keep = warn_live;
		anim_live = anim_on_q && (ad < 32'd1000);
		o_anim_keep = anim_on_q;
		o_r = 1'b0; o_g = 1'b0; o_b = 1'b0;
		if (lstep_q != LS_IDLE) begin
			case (lstep_q)
				LS_NEW:   begin o_g = !blink; o_b = blink; end
				LS_ADMIN: begin o_r = !blink; o_b = blink; end
				LS_OK:    o_g = 1'b1;
				default:  o_r = 1'b1;
			endcase
		end else if (warn_live) begin
			o_r = warn_ph;
		end else if (lock_q || alarm_q) begin
			o_r = 1'b1;
		end else if (anim_live) begin
			o_g = anim_unl_q && anim_ph;
			o_b = !anim_unl_q && anim_ph;
		end else begin
			o_anim_keep = 1'b0;
			o_g = unl_q; o_b = !unl_q;
		end
	end

	// ---- sequencer ----
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; op_q <= OP_TICK; uid_q <= '0; scan_q <= '0;
			rd_pend_q <= 1'b0; found_q <= 1'b0; found_idx_q <= '0;
			count_q <= CntW'(1);
			pending_q <= '0; unl_uid_q <= '0; bound_q <= 1'b0; unl_q <= 1'b0;
			alarm_q <= 1'b0; lock_q <= 1'b0; await_q <= 1'b0; streak_q <= '0;
			ok_q <= '0; bad_q <= '0; lstep_q <= LS_IDLE; status_q <= ST_READY;
			now_q <= '0; alarm_since_q <= '0; learn_since_q <= '0; fb_since_q <= '0;
			warn_since_q <= '0; anim_since_q <= '0;
			warn_on_q <= 1'b0; anim_on_q <= 1'b0; anim_unl_q <= 1'b0;
			blk_cnt_q <= '0; blink_q <= 1'b0;
			done <= 1'b0;
			access_state <= '0; learn_phase <= '0; is_unlocked <= 1'b0;
			alarm_active <= 1'b0; lockout_active <= 1'b0; wrong_card_warning <= 1'b0;
			failure_streak <= '0; success_total <= '0; failure_total <= '0;
			led_red <= 1'b0; led_green <= 1'b0; led_blue <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= op_t'(opcode); uid_q <= card_uid;
						scan_q <= '0; found_q <= 1'b0; rd_pend_q <= 1'b0;
						state_q <= (op_t'(opcode) == OP_CARD) ? S_SCAN : S_EXEC;
					end
				end
				// one entry per cycle; entry 0 compares against the admin register
				S_SCAN: begin
					if (rd_pend_q && !found_q) begin
						if (((scan_q - 1'b1) == '0 ? admin_q : rd_data_q) == uid_q) begin
							found_q <= 1'b1;
							found_idx_q <= IdxW'(scan_q - 1'b1);
						end
					end
					if (scan_q < count_q && scan_q < CntW'(MaxCards) && !found_q &&
					    !(rd_pend_q && (((scan_q - 1'b1) == '0 ? admin_q : rd_data_q) == uid_q))) begin
						scan_q <= scan_q + 1'b1;
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (!rd_pend_q || found_q ||
						    (((scan_q - 1'b1) == '0 ? admin_q : rd_data_q) == uid_q) ||
						    scan_q >= count_q || scan_q >= CntW'(MaxCards))
							state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					now_q <= now_n;
					// blink phase follows now / 250, restarting when now wraps
					if (op_q == OP_TICK) begin
						if (now_q == '1) begin
							blk_cnt_q <= '0; blink_q <= 1'b0;
						end else if (blk_cnt_q == 8'd249) begin
							blk_cnt_q <= '0; blink_q <= !blink_q;
						end else begin
							blk_cnt_q <= blk_cnt_q + 8'd1;
						end
					end
					alarm_q <= n_alarm; unl_q <= n_unl; bound_q <= n_bound; lock_q <= n_lock;
					await_q <= n_await; warn_on_q <= n_warn_on; anim_on_q <= n_anim_on;
					anim_unl_q <= n_anim_unl; lstep_q <= n_lstep; status_q <= n_status;
					streak_q <= n_streak; ok_q <= n_ok; bad_q <= n_bad;
					pending_q <= n_pending; unl_uid_q <= n_unl_uid;
					alarm_since_q <= n_alarm_since; learn_since_q <= n_learn_since;
					fb_since_q <= n_fb_since; warn_since_q <= n_warn_since;
					anim_since_q <= n_anim_since; count_q <= n_count;
					state_q <= S_OUT;
				end
				S_OUT: begin
					warn_on_q <= o_warn_keep;
					anim_on_q <= o_anim_keep;
					access_state <= status_q; learn_phase <= lstep_q;
					is_unlocked <= unl_q; alarm_active <= alarm_q;
					lockout_active <= lock_q; wrong_card_warning <= warn_live;
					failure_streak <= streak_q; success_total <= ok_q;
					failure_total <= bad_q;
					led_red <= o_r; led_green <= o_g; led_blue <= o_b;
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- checks ----
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CntW'(1)) && (count_q <= CntW'(MaxCards)))
		else $error("card count out of range");
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> done) else $error("missing done");
	a_wr_learn: assert property (@(posedge clk) disable iff (!arst_n)
		wl_we |-> (state_q == S_EXEC && lstep_q == LS_ADMIN))
		else $error("stray whitelist write");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(wl_we)))
		else $error("card count changed without write");
endmodule
`default_nettype wire
